@@ rtl/mtf_pkg.sv @@
// Package for the move-to-front search table.
// Holds the field widths, default depth, codes and state type used by the core, interfaces, checker and testbench.
// Depends on nothing.
`default_nettype none

package mtf_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int KEY_W         = 32;
  localparam int STATUS_W      = 2;
  localparam int POS_W         = 5;
  localparam int COUNT_W       = 5;

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_PUSHED    = 2'd0,
    STATUS_FOUND     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FRONT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/mtf_in_if.sv @@
// Request channel of the move-to-front search table: valid, ready, opcode and key.
// Depends on mtf_pkg for the key width.
`default_nettype none

interface mtf_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic signed [mtf_pkg::KEY_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink (input valid, input opcode, input key, output ready);
endinterface

`default_nettype wire

@@ rtl/mtf_out_if.sv @@
// Result channel of the move-to-front search table: valid, ready, status, position, count.
// Depends on mtf_pkg for the field widths.
`default_nettype none

interface mtf_out_if;
  logic                          valid;
  logic                          ready;
  logic [mtf_pkg::STATUS_W-1:0]  status;
  logic [mtf_pkg::POS_W-1:0]     position;
  logic [mtf_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink (input valid, input status, input position, input entry_count,
                output ready);
endinterface

`default_nettype wire

@@ rtl/move_to_front_search_table_core.sv @@
// Top level of the move-to-front search table.
// Depends on mtf_pkg, mtf_in_if, mtf_out_if and mtf_ram.
//
// The block holds up to DEPTH signed 32-bit keys in one key memory, front first. A push
// puts its key at the front; a push to a full table is refused with status full. A search
// scans from the front for the first equal key and, on a hit, moves that entry to the
// front. One request is processed at a time and the next transfer is taken once the
// previous result has been handed to the result register, which may still be waiting.
// A push shifts the held entries back by one and writes its key at the front; a search
// that hits shifts the entries ahead of the hit back by one and writes the key at the
// front, and a miss scans every held entry. The single read port of the key memory sets
// the pace: the scan reads one entry a cycle and the shift moves one entry a cycle.
`default_nettype none

module move_to_front_search_table_core #(
  parameter int DEPTH = mtf_pkg::DEPTH_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  mtf_in_if.sink     req,
  mtf_out_if.source  rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mtf_pkg::state_t               state, state_next;
  logic [CW-1:0]                 count, count_next;
  logic [mtf_pkg::KEY_W-1:0]     op_key, op_key_next;
  logic [CW-1:0]                 ridx, ridx_next;
  logic [AW-1:0]                 cidx, cidx_next;
  logic                          cmp_ok, cmp_ok_next;
  logic [AW-1:0]                 sidx, sidx_next;
  logic [AW-1:0]                 lastrd, lastrd_next;
  logic                          sh_ok, sh_ok_next;
  mtf_pkg::status_t              res_status, res_status_next;
  logic [CW-1:0]                 res_pos, res_pos_next;
  logic                          out_valid, out_valid_next;
  mtf_pkg::status_t              out_status, out_status_next;
  logic [mtf_pkg::POS_W-1:0]     out_position, out_position_next;
  logic [mtf_pkg::COUNT_W-1:0]   out_count, out_count_next;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [mtf_pkg::KEY_W-1:0]     ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [mtf_pkg::KEY_W-1:0]     ram_rdata;

  mtf_ram #(
    .WIDTH (mtf_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready       = (state == mtf_pkg::ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = out_position;
  assign rsp.entry_count = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtf_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      cmp_ok    <= 1'b0;
      sh_ok     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      cmp_ok    <= cmp_ok_next;
      sh_ok     <= sh_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    op_key       <= op_key_next;
    ridx         <= ridx_next;
    cidx         <= cidx_next;
    sidx         <= sidx_next;
    lastrd       <= lastrd_next;
    res_status   <= res_status_next;
    res_pos      <= res_pos_next;
    out_status   <= out_status_next;
    out_position <= out_position_next;
    out_count    <= out_count_next;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    op_key_next       = op_key;
    ridx_next         = ridx;
    cidx_next         = cidx;
    cmp_ok_next       = cmp_ok;
    sidx_next         = sidx;
    lastrd_next       = lastrd;
    sh_ok_next        = sh_ok;
    res_status_next   = res_status;
    res_pos_next      = res_pos;
    out_valid_next    = out_valid && !rsp.ready;
    out_status_next   = out_status;
    out_position_next = out_position;
    out_count_next    = out_count;
    ram_we            = 1'b0;
    ram_waddr         = '0;
    ram_wdata         = op_key;
    ram_raddr         = ridx[AW-1:0];

    unique case (state)
      mtf_pkg::ST_IDLE: begin
        if (req.valid) begin
          op_key_next  = req.key;
          res_pos_next = '0;
          ridx_next    = '0;
          cmp_ok_next  = 1'b0;
          sh_ok_next   = 1'b0;
          if (req.opcode == mtf_pkg::OP_PUSH) begin
            if (count == CW'(DEPTH)) begin
              res_status_next = mtf_pkg::STATUS_FULL;
              state_next      = mtf_pkg::ST_FINISH;
            end else begin
              res_status_next = mtf_pkg::STATUS_PUSHED;
              count_next      = count + 1'b1;
              if (count == '0) begin
                state_next = mtf_pkg::ST_FRONT;
              end else begin
                sidx_next  = AW'(count - 1'b1);
                state_next = mtf_pkg::ST_SHIFT;
              end
            end
          end else begin
            res_status_next = mtf_pkg::STATUS_NOT_FOUND;
            if (count == '0) begin
              state_next = mtf_pkg::ST_FINISH;
            end else begin
              state_next = mtf_pkg::ST_SCAN;
            end
          end
        end
      end

      mtf_pkg::ST_SCAN: begin
        ram_raddr = ridx[AW-1:0];
        if (cmp_ok && (ram_rdata == op_key)) begin
          res_status_next = mtf_pkg::STATUS_FOUND;
          res_pos_next    = CW'(cidx) + 1'b1;
          cmp_ok_next     = 1'b0;
          if (cidx == '0) begin
            state_next = mtf_pkg::ST_FRONT;
          end else begin
            sidx_next  = cidx - 1'b1;
            state_next = mtf_pkg::ST_SHIFT;
          end
        end else if (cmp_ok && (CW'(cidx) == count - 1'b1)) begin
          cmp_ok_next = 1'b0;
          state_next  = mtf_pkg::ST_FINISH;
        end else begin
          cmp_ok_next = (ridx < count);
          cidx_next   = ridx[AW-1:0];
          ridx_next   = ridx + 1'b1;
        end
      end

      mtf_pkg::ST_SHIFT: begin
        ram_raddr = sidx;
        ram_we    = sh_ok;
        ram_waddr = lastrd + 1'b1;
        ram_wdata = ram_rdata;
        if (sh_ok && (lastrd == '0)) begin
          sh_ok_next = 1'b0;
          state_next = mtf_pkg::ST_FRONT;
        end else begin
          lastrd_next = sidx;
          sh_ok_next  = 1'b1;
          sidx_next   = sidx - 1'b1;
        end
      end

      mtf_pkg::ST_FRONT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = op_key;
        state_next = mtf_pkg::ST_FINISH;
      end

      mtf_pkg::ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next    = 1'b1;
          out_status_next   = res_status;
          out_position_next = mtf_pkg::POS_W'(res_pos);
          out_count_next    = mtf_pkg::COUNT_W'(count);
          state_next        = mtf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mtf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/mtf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module mtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/mtf_checker.sv @@
// Port-level checker for the move-to-front search table, with its bind to the top level.
// Depends on mtf_pkg and move_to_front_search_table_core.
`default_nettype none

module mtf_checker #(
  parameter int DEPTH = mtf_pkg::DEPTH_DEFAULT
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [mtf_pkg::STATUS_W-1:0] status,
  input wire logic [mtf_pkg::POS_W-1:0]    position,
  input wire logic [mtf_pkg::COUNT_W-1:0]  entry_count
);

  // A stalled result stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
      && $stable(entry_count))
    else $error("result changed or dropped while stalled");

  // Requests are processed one at a time, so ready drops after each request transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request transfer");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == mtf_pkg::STATUS_FULL) |->
      (position == '0) && (entry_count == mtf_pkg::COUNT_W'(DEPTH)))
    else $error("full refusal with wrong position or count");

  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == mtf_pkg::STATUS_FOUND) |->
      (DEPTH >= 32) || ((position != '0) && (position <= entry_count)))
    else $error("found position outside the held entries");

  a_no_position: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == mtf_pkg::STATUS_PUSHED) || (status == mtf_pkg::STATUS_NOT_FOUND))
      |-> (position == '0))
    else $error("nonzero position without a hit");

endmodule

bind move_to_front_search_table_core mtf_checker #(
  .DEPTH (DEPTH)
) u_mtf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .status      (rsp.status),
  .position    (rsp.position),
  .entry_count (rsp.entry_count)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for move_to_front_search_table_core: random and directed push and search requests.
// A local copy of the move-to-front table predicts every result; results are checked in order.
// Depends on mtf_pkg, mtf_in_if, mtf_out_if and the core.
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_DEPTH  = mtf_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CALM_TAIL    = 150;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    mtf_pkg::opcode_t               op;
    logic [mtf_pkg::KEY_W-1:0]      key;
  } request_t;

  typedef struct {
    mtf_pkg::status_t               status;
    logic [mtf_pkg::POS_W-1:0]      position;
    logic [mtf_pkg::COUNT_W-1:0]    entry_count;
  } outcome_t;

  logic clk;
  logic rst;

  mtf_in_if  req_ch ();
  mtf_out_if rsp_ch ();

  move_to_front_search_table_core #(.DEPTH(TABLE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  request_t                   requests_pending[$];
  outcome_t                   outcomes_due[$];
  logic [mtf_pkg::KEY_W-1:0]  key_table[TABLE_DEPTH];
  int                         keys_held;
  logic [mtf_pkg::KEY_W-1:0]  planned_keys[$];
  int                         total_items;
  int                         items_taken;
  int                         mismatches;
  int                         status_tally[4];
  int                         deepest_hit;
  logic                       req_took;
  int                         req_gap;
  int                         rsp_gap;

  always #5 clk = ~clk;

  // Move-to-front table update for one request; returns the result it causes.
  function automatic outcome_t apply_request(mtf_pkg::opcode_t op,
                                             logic [mtf_pkg::KEY_W-1:0] k);
    outcome_t r;
    int hit;
    r.position = '0;
    hit = -1;
    if (op == mtf_pkg::OP_PUSH) begin
      if (keys_held >= TABLE_DEPTH) begin
        r.status = mtf_pkg::STATUS_FULL;
      end else begin
        for (int i = keys_held; i > 0; i--) key_table[i] = key_table[i-1];
        key_table[0] = k;
        keys_held++;
        r.status = mtf_pkg::STATUS_PUSHED;
      end
    end else begin
      for (int i = 0; i < keys_held; i++) begin
        if (hit < 0 && key_table[i] == k) hit = i;
      end
      if (hit >= 0) begin
        for (int i = hit; i > 0; i--) key_table[i] = key_table[i-1];
        key_table[0] = k;
        r.status = mtf_pkg::STATUS_FOUND;
        r.position = mtf_pkg::POS_W'(hit + 1);
      end else begin
        r.status = mtf_pkg::STATUS_NOT_FOUND;
      end
    end
    r.entry_count = mtf_pkg::COUNT_W'(keys_held);
    return r;
  endfunction

  task automatic queue_request(mtf_pkg::opcode_t op, logic [mtf_pkg::KEY_W-1:0] k);
    request_t item;
    item.op = op;
    item.key = k;
    requests_pending.push_back(item);
    if (op == mtf_pkg::OP_PUSH && planned_keys.size() < TABLE_DEPTH) planned_keys.push_back(k);
  endtask

  task automatic report_field(string field, int expv, int actv);
    $display("%0t: %s expected %0d, actual %0d", $time, field, expv, actv);
    mismatches++;
  endtask

  function automatic logic [mtf_pkg::KEY_W-1:0] extreme_key();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Request side: takes the next pending item once the current one has been transferred.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_took) begin
    end else if (req_gap > 0) begin
      req_ch.valid <= 1'b0;
      req_gap <= req_gap - 1;
    end else if (requests_pending.size() > 0) begin
      if (items_taken < total_items - CALM_TAIL && $urandom_range(0, 5) == 0) begin
        req_ch.valid <= 1'b0;
        req_gap <= $urandom_range(0, 3);
      end else begin
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= requests_pending[0].op;
        req_ch.key    <= requests_pending[0].key;
        void'(requests_pending.pop_front());
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Result side: stalls in short random bursts until the last part of the run.
  always @(negedge clk) begin
    if (rsp_gap > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap <= rsp_gap - 1;
    end else if (items_taken < total_items - CALM_TAIL && $urandom_range(0, 4) == 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap <= $urandom_range(0, 3);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    req_took <= req_ch.valid && req_ch.ready && !rst;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status      = mtf_pkg::status_t'(rsp_ch.status);
      got.position    = rsp_ch.position;
      got.entry_count = rsp_ch.entry_count;
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d position %0d count %0d",
                 $time, got.status, got.position, got.entry_count);
        mismatches++;
      end else begin
        want = outcomes_due.pop_front();
        if (got.status !== want.status) report_field("status", want.status, got.status);
        if (got.position !== want.position)
          report_field("position", want.position, got.position);
        if (got.entry_count !== want.entry_count)
          report_field("entry_count", want.entry_count, got.entry_count);
      end
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      want = apply_request(mtf_pkg::opcode_t'(req_ch.opcode), req_ch.key);
      outcomes_due.push_back(want);
      status_tally[want.status]++;
      if (want.status == mtf_pkg::STATUS_FOUND && want.position > deepest_hit)
        deepest_hit = want.position;
      items_taken <= items_taken + 1;
    end
  end

  initial begin : run_timeout
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int roll;
    logic [mtf_pkg::KEY_W-1:0] k;
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = mtf_pkg::OP_PUSH;
    req_ch.key = '0;
    rsp_ch.ready = 1'b0;
    req_took = 1'b0;
    req_gap = 0;
    rsp_gap = 0;
    keys_held = 0;
    items_taken = 0;
    mismatches = 0;
    deepest_hit = 0;
    for (int i = 0; i < 4; i++) status_tally[i] = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) key_table[i] = '0;

    queue_request(mtf_pkg::OP_SEARCH, 32'h0000_0000);
    queue_request(mtf_pkg::OP_PUSH, 32'h8000_0000);
    queue_request(mtf_pkg::OP_PUSH, 32'h7FFF_FFFF);
    queue_request(mtf_pkg::OP_PUSH, 32'h0000_0000);
    queue_request(mtf_pkg::OP_PUSH, 32'hFFFF_FFFF);
    queue_request(mtf_pkg::OP_SEARCH, 32'hFFFF_FFFF);
    queue_request(mtf_pkg::OP_SEARCH, 32'h8000_0000);
    queue_request(mtf_pkg::OP_SEARCH, 32'h0000_3039);
    queue_request(mtf_pkg::OP_PUSH, 32'h7FFF_FFFF);
    queue_request(mtf_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    queue_request(mtf_pkg::OP_SEARCH, 32'h5555_5555);
    queue_request(mtf_pkg::OP_SEARCH, 32'hAAAA_AAAA);
    queue_request(mtf_pkg::OP_PUSH, 32'h5555_5555);
    queue_request(mtf_pkg::OP_PUSH, 32'hAAAA_AAAA);
    queue_request(mtf_pkg::OP_SEARCH, 32'h8000_0000);
    queue_request(mtf_pkg::OP_SEARCH, 32'h0000_0000);
    queue_request(mtf_pkg::OP_SEARCH, 32'h0000_0000);

    // Pushes are rare so that the table passes slowly through every fill level.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if ((planned_keys.size() < TABLE_DEPTH && roll < 6) ||
          (planned_keys.size() == TABLE_DEPTH && roll < 10)) begin
        case ($urandom_range(0, 3))
          0, 1: k = $urandom;
          2: k = extreme_key();
          default: k = planned_keys[$urandom_range(0, planned_keys.size() - 1)];
        endcase
        queue_request(mtf_pkg::OP_PUSH, k);
      end else begin
        k = planned_keys[$urandom_range(0, planned_keys.size() - 1)];
        case ($urandom_range(0, 7))
          6: k = $urandom;
          7: k = k ^ (32'h1 << $urandom_range(0, mtf_pkg::KEY_W - 1));
          default: ;
        endcase
        queue_request(mtf_pkg::OP_SEARCH, k);
      end
    end
    total_items = requests_pending.size();

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (items_taken != total_items || outcomes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d requests: %0d pushes, %0d refused on a full table, %0d hits, %0d misses.",
             total_items, status_tally[mtf_pkg::STATUS_PUSHED],
             status_tally[mtf_pkg::STATUS_FULL], status_tally[mtf_pkg::STATUS_FOUND],
             status_tally[mtf_pkg::STATUS_NOT_FOUND]);
    $display("Deepest hit was at position %0d of %0d.", deepest_hit, TABLE_DEPTH);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
